FILE: hdl/rtfx_pkg.sv
// Shared types and helper functions for the RTF text extractor.
package rtfx_pkg;

	// Default depth of the result queue between parser and output stage
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Character codes used by the parser
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_BSLASH    = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h27;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [3:0] HEX_ALPHA_OFS = 4'd10;

	// Candidate word indexes into the match mask
	localparam logic [1:0] WORD_PAR  = 2'd0;
	localparam logic [1:0] WORD_LINE = 2'd1;
	localparam logic [1:0] WORD_TAB  = 2'd2;
	localparam logic [2:0] LEN_PAR   = 3'd3;
	localparam logic [2:0] LEN_LINE  = 3'd4;
	localparam logic [2:0] LEN_TAB   = 3'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       has_byte;
		logic       end_of_text;
	} out_item_t;

	// Up to two results caused by one input beat
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
	} res_set_t;

	// Append one text byte, dropping it once two are held
	function automatic res_set_t push_byte(res_set_t s, logic [7:0] b);
		res_set_t t;
		t = s;
		if (s.cnt == 2'd0) begin
			t.r0 = '{text_byte: b, has_byte: 1'b1, end_of_text: 1'b0};
			t.cnt = 2'd1;
		end else if (s.cnt == 2'd1) begin
			t.r1 = '{text_byte: b, has_byte: 1'b1, end_of_text: 1'b0};
			t.cnt = 2'd2;
		end
		return t;
	endfunction

endpackage

FILE: hdl/rtfx_front.sv
// Parser front end: accepts source bytes and forms the result set of each beat.
module rtfx_front import rtfx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     q_push,
	output res_set_t q_wdata
);

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_ESC     = 3'd1;
	localparam logic [2:0] MODE_QUOTE   = 3'd2;
	localparam logic [2:0] MODE_HEXHALF = 3'd3;
	localparam logic [2:0] MODE_WORD    = 3'd4;
	localparam logic [2:0] MODE_NUM     = 3'd5;

	logic [2:0] mode_q, mode_d;
	logic [7:0] held_q, held_d;
	logic [2:0] wlen_q, wlen_d;
	logic [2:0] wmatch_q, wmatch_d;
	logic       accept;
	res_set_t   res;

	function automatic logic is_letter(logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	// Return {valid, value} of one hex digit
	function automatic logic [4:0] hex_value(logic [7:0] b);
		logic [7:0] d;
		logic [4:0] r;
		r = 5'd0;
		d = 8'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			d = b - 8'h30;
			r = {1'b1, d[3:0]};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d = b - 8'h61;
			r = {1'b1, d[3:0] + HEX_ALPHA_OFS};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d = b - 8'h41;
			r = {1'b1, d[3:0] + HEX_ALPHA_OFS};
		end
		return r;
	endfunction

	// True if letter b fits candidate k at position pos
	function automatic logic letter_fits(logic [1:0] k, logic [2:0] pos, logic [7:0] b);
		logic ok;
		ok = 1'b0;
		unique case (k)
			WORD_PAR: begin
				unique case (pos)
					3'd0: ok = (b == 8'h70);
					3'd1: ok = (b == 8'h61);
					3'd2: ok = (b == 8'h72);
					default: ok = 1'b0;
				endcase
			end
			WORD_LINE: begin
				unique case (pos)
					3'd0: ok = (b == 8'h6C);
					3'd1: ok = (b == 8'h69);
					3'd2: ok = (b == 8'h6E);
					3'd3: ok = (b == 8'h65);
					default: ok = 1'b0;
				endcase
			end
			WORD_TAB: begin
				unique case (pos)
					3'd0: ok = (b == 8'h74);
					3'd1: ok = (b == 8'h61);
					3'd2: ok = (b == 8'h62);
					default: ok = 1'b0;
				endcase
			end
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Judge a finished control word: {valid, byte}
	function automatic logic [8:0] word_result(logic [2:0] len, logic [2:0] m);
		logic [8:0] r;
		r = 9'd0;
		if ((m[WORD_PAR] && len == LEN_PAR) || (m[WORD_LINE] && len == LEN_LINE)) begin
			r = {1'b1, CH_NEWLINE};
		end else if (m[WORD_TAB] && len == LEN_TAB) begin
			r = {1'b1, CH_TAB};
		end
		return r;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Parse one byte, then finish pending work at end of document
	always_comb begin
		logic [7:0] b;
		logic       do_word;
		logic       do_plain;
		logic [7:0] plain_b;
		logic [4:0] hi;
		logic [4:0] lo;
		logic [8:0] wr;
		b        = in_data.data_byte;
		mode_d   = mode_q;
		held_d   = held_q;
		wlen_d   = wlen_q;
		wmatch_d = wmatch_q;
		res      = '0;
		do_word  = 1'b0;
		do_plain = 1'b0;
		plain_b  = b;
		hi       = hex_value(held_q);
		lo       = hex_value(b);
		wr       = 9'd0;

		unique case (mode_q)
			MODE_ESC: begin
				if (b == CH_BSLASH || b == CH_LBRACE || b == CH_RBRACE) begin
					res = push_byte(res, b);
					mode_d = MODE_NORMAL;
				end else if (b == CH_QUOTE) begin
					mode_d = MODE_QUOTE;
				end else begin
					wlen_d   = 3'd0;
					wmatch_d = 3'b111;
					mode_d   = MODE_WORD;
					do_word  = 1'b1;
				end
			end
			MODE_QUOTE: begin
				held_d = b;
				mode_d = MODE_HEXHALF;
			end
			MODE_HEXHALF: begin
				if (hi[4]) begin
					res = push_byte(res, lo[4] ? {hi[3:0], lo[3:0]} : {4'd0, hi[3:0]});
				end
				mode_d = MODE_NORMAL;
			end
			MODE_WORD, MODE_NUM: do_word = 1'b1;
			default: do_plain = 1'b1;
		endcase

		// Advance an open control word
		if (do_word) begin
			if (mode_d == MODE_WORD && is_letter(b)) begin
				for (int k = 0; k < 3; k++) begin
					if (!letter_fits(2'(k), wlen_d, b)) begin
						wmatch_d[k] = 1'b0;
					end
				end
				if (wlen_d != 3'd7) begin
					wlen_d = wlen_d + 3'd1;
				end
			end else if (mode_d == MODE_WORD && (b == CH_MINUS || is_digit(b))) begin
				mode_d = MODE_NUM;
			end else if (mode_d == MODE_NUM && is_digit(b)) begin
				mode_d = MODE_NUM;
			end else begin
				wr = word_result(wlen_d, wmatch_d);
				if (wr[8]) begin
					res = push_byte(res, wr[7:0]);
				end
				mode_d = MODE_NORMAL;
				do_plain = (b != CH_SPACE);
			end
		end

		// Handle the byte as ordinary text
		if (do_plain) begin
			mode_d = MODE_NORMAL;
			if (b == CH_BSLASH) begin
				mode_d = MODE_ESC;
			end else if (b != CH_LBRACE && b != CH_RBRACE) begin
				res = push_byte(res, b);
			end
		end

		// Flush pending escape at end of document and restart
		if (in_data.end_of_source) begin
			unique case (mode_d)
				MODE_WORD, MODE_NUM: begin
					wr = word_result(wlen_d, wmatch_d);
					if (wr[8]) begin
						res = push_byte(res, wr[7:0]);
					end
				end
				MODE_QUOTE: res = push_byte(res, CH_QUOTE);
				MODE_HEXHALF: begin
					res = push_byte(res, CH_QUOTE);
					plain_b = held_d;
					if (plain_b != CH_BSLASH && plain_b != CH_LBRACE &&
					    plain_b != CH_RBRACE) begin
						res = push_byte(res, plain_b);
					end
				end
				default: res = res;
			endcase
			if (res.cnt == 2'd0) begin
				res.cnt = 2'd1;
				res.r0  = '{text_byte: 8'd0, has_byte: 1'b0, end_of_text: 1'b1};
			end else if (res.cnt == 2'd1) begin
				res.r0.end_of_text = 1'b1;
			end else begin
				res.r1.end_of_text = 1'b1;
			end
			mode_d   = MODE_NORMAL;
			held_d   = 8'd0;
			wlen_d   = 3'd0;
			wmatch_d = 3'b111;
		end
	end

	assign q_push  = accept && (res.cnt != 2'd0);
	assign q_wdata = res;

	// Update parse state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			held_q   <= 8'd0;
			wlen_q   <= 3'd0;
			wmatch_q <= 3'b111;
		end else if (accept) begin
			mode_q   <= mode_d;
			held_q   <= held_d;
			wlen_q   <= wlen_d;
			wmatch_q <= wmatch_d;
		end
	end

endmodule

FILE: hdl/rtfx_queue.sv
// Short queue of result sets between the parser and the output stage.
module rtfx_queue import rtfx_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  res_set_t wdata,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output res_set_t rdata
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	res_set_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/rtfx_back.sv
// Output stage: sends the results of each queued set one beat at a time.
module rtfx_back import rtfx_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_not_empty,
	input  res_set_t  q_rdata,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic sel_q;
	logic beat;
	logic last_of_set;

	assign out_valid   = q_not_empty;
	assign out_data    = sel_q ? q_rdata.r1 : q_rdata.r0;
	assign beat        = out_valid && out_ready;
	assign last_of_set = sel_q || (q_rdata.cnt != 2'd2);
	assign q_pop       = beat && last_of_set;

	// Step through the results of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (beat) begin
			sel_q <= !last_of_set;
		end
	end

endmodule

FILE: hdl/rtf_text_extractor_core.sv
// Top level of the RTF text extractor: parser, result queue and output stage.
//
// Usage: source bytes enter on the in channel (valid/ready), one per beat, with
// end_of_source set on the last byte of a document. Plain text leaves on the
// out channel, one byte per beat; end_of_text marks the final beat of a
// document, and a beat with has_byte low is a bare end marker.
// Each result set is registered in the queue and offered on out from its head.
// Throughput: one source byte per cycle while the queue has room; a byte that
// yields two text bytes is sent as two output beats, so the sustained rate is
// set by the single-beat output port draining the queue.
// The queue holds QUEUE_DEPTH result sets; in_ready drops when it is full.
// When the receiver stalls, the head result holds steady on out and the parser
// keeps taking bytes until the queue fills.
// Reset: arst_n clears the parse state and empties the queue; no results are
// pending afterwards. At end of document the parse state returns to its reset
// values so the next byte starts a new document.
module rtf_text_extractor_core import rtfx_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_not_empty;
	res_set_t q_wdata;
	res_set_t q_rdata;

	rtfx_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	rtfx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	rtfx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
